@@ hw/rtl/tabular_q_learning_engine_unit_defines.svh @@
// Assertion macros for the Q-learning engine.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TABULAR_Q_LEARNING_ENGINE_UNIT_DEFINES_SVH
`define TABULAR_Q_LEARNING_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TQLE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TQLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tqle_pkg.sv @@
// Shared constants and types for the tabular Q-learning engine.
// No dependencies.
package tqle_pkg;

  localparam int NUM_ACTIONS = 4;
  localparam int ACT_W       = 2;
  localparam int COORD_W     = 8;
  localparam int REWARD_W    = 8;
  localparam int PCT_W       = 7;
  localparam int RATE_W      = 9;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_VAL_W   = 16;

  localparam logic [RATE_W-1:0] RATE_ONE      = 9'd256;
  localparam logic [RATE_W-1:0] LR_RESET      = 9'd128;
  localparam logic [RATE_W-1:0] DISC_RESET    = 9'd243;
  localparam logic [PCT_W-1:0]  EXPLORE_RESET = 7'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_PERCENT = 2'd2;

  // Stage enables for the update datapath
  typedef struct packed {
    logic mul1_en;
    logic mul2_en;
  } upd_ctl_t;

endpackage

@@ hw/rtl/tqle_in_if.sv @@
// Input item channel: valid/ready handshake plus one step's fields.
// Depends on tqle_pkg.
interface tqle_in_if;
  logic                                valid;
  logic                                ready;
  logic                                do_update;
  logic [tqle_pkg::COORD_W-1:0]        prev_x;
  logic [tqle_pkg::COORD_W-1:0]        prev_y;
  logic [tqle_pkg::ACT_W-1:0]          prev_action;
  logic signed [tqle_pkg::REWARD_W-1:0] step_reward;
  logic [tqle_pkg::COORD_W-1:0]        cur_x;
  logic [tqle_pkg::COORD_W-1:0]        cur_y;
  logic [tqle_pkg::PCT_W-1:0]          rand_percent;
  logic [tqle_pkg::ACT_W-1:0]          rand_action;

  modport source (
    output valid, do_update, prev_x, prev_y, prev_action, step_reward,
           cur_x, cur_y, rand_percent, rand_action,
    input  ready
  );
  modport sink (
    input  valid, do_update, prev_x, prev_y, prev_action, step_reward,
           cur_x, cur_y, rand_percent, rand_action,
    output ready
  );
endinterface

@@ hw/rtl/tqle_out_if.sv @@
// Result channel: valid/ready handshake plus chosen action and updated value.
// Depends on tqle_pkg.
interface tqle_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tqle_pkg::ACT_W-1:0]            next_action;
  logic                                  explored;
  logic signed [tqle_pkg::OUT_VAL_W-1:0] new_value;

  modport source (output valid, next_action, explored, new_value, input ready);
  modport sink   (input valid, next_action, explored, new_value, output ready);
endinterface

@@ hw/rtl/tqle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tqle_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tqle_update.sv @@
// Q-learning update datapath: two multiply stages, then scaling and saturation.
// Depends on tqle_pkg.
module tqle_update #(
  parameter int Q_WIDTH = 16
) (
  input  logic                                  clk,
  input  tqle_pkg::upd_ctl_t                    ctl,
  input  logic signed [Q_WIDTH-1:0]             q_old,
  input  logic signed [Q_WIDTH-1:0]             q_max,
  input  logic signed [tqle_pkg::REWARD_W-1:0]  reward,
  input  logic [tqle_pkg::RATE_W-1:0]           alpha,
  input  logic [tqle_pkg::RATE_W-1:0]           gamma,
  output logic signed [Q_WIDTH-1:0]             new_val
);

  localparam int P1_W = Q_WIDTH + 10;
  localparam int P2_W = Q_WIDTH + 11;
  localparam int NW   = Q_WIDTH + 22;
  localparam int TW   = NW - 16;

  localparam logic signed [TW-1:0] T_MAX = $signed({7'b0000000, {(Q_WIDTH-1){1'b1}}});
  localparam logic signed [TW-1:0] T_MIN = $signed({7'b1111111, {(Q_WIDTH-1){1'b0}}});

  logic signed [P1_W-1:0] p1_r, p1_nxt;
  logic signed [P2_W-1:0] p2_r, p2_nxt;
  logic signed [NW-1:0]   n_r, n_nxt;
  logic signed [P1_W-1:0] gm;
  logic signed [15:0]     r256;
  logic signed [P1_W+7:0] p1_sh;
  logic signed [P2_W+9:0] ap2;
  logic [tqle_pkg::RATE_W-1:0] inv_alpha;
  logic signed [NW-1:0]   n_adj;
  logic signed [TW-1:0]   t;

  always_comb begin
    inv_alpha = tqle_pkg::RATE_ONE - alpha;
    p1_nxt    = $signed({1'b0, inv_alpha}) * q_old;
    gm        = $signed({1'b0, gamma}) * q_max;
    r256      = $signed({reward, 8'b0});
    p2_nxt    = P2_W'(gm) + P2_W'(r256);
  end

  always_comb begin
    p1_sh = $signed({p1_r, 8'b0});
    ap2   = $signed({1'b0, alpha}) * p2_r;
    n_nxt = NW'(p1_sh) + NW'(ap2);
  end

  // Truncate toward zero by 512, then floor by 128: one bias, one shift
  always_comb begin
    n_adj = n_r + (n_r[NW-1] ? NW'(511) : NW'(0));
    t     = TW'(n_adj >>> 16);
    if (t > T_MAX) begin
      new_val = $signed({1'b0, {(Q_WIDTH-1){1'b1}}});
    end else if (t < T_MIN) begin
      new_val = $signed({1'b1, {(Q_WIDTH-1){1'b0}}});
    end else begin
      new_val = t[Q_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul1_en) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (ctl.mul2_en) begin
      n_r <= n_nxt;
    end
  end

endmodule

@@ hw/rtl/tqle_choose.sv @@
// Epsilon-greedy action choice over one row of four Q values.
// Depends on tqle_pkg.
module tqle_choose #(
  parameter int Q_WIDTH = 16
) (
  input  logic [tqle_pkg::NUM_ACTIONS*Q_WIDTH-1:0] row,
  input  logic [tqle_pkg::PCT_W-1:0]               rand_percent,
  input  logic [tqle_pkg::PCT_W-1:0]               explore_percent,
  input  logic [tqle_pkg::ACT_W-1:0]               rand_action,
  output logic [tqle_pkg::ACT_W-1:0]               next_action,
  output logic                                     explored
);

  logic signed [Q_WIDTH-1:0]   ent [tqle_pkg::NUM_ACTIONS];
  logic signed [Q_WIDTH+1:0]   sum;
  logic signed [Q_WIDTH-1:0]   best_val;
  logic [tqle_pkg::ACT_W-1:0]  best_idx;

  always_comb begin
    for (int k = 0; k < tqle_pkg::NUM_ACTIONS; k++) begin
      ent[k] = row[k*Q_WIDTH +: Q_WIDTH];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < tqle_pkg::NUM_ACTIONS; k++) begin
      sum = sum + (Q_WIDTH+2)'(ent[k]);
    end
  end

  // Strict compare keeps the lowest index on ties
  always_comb begin
    best_val = ent[0];
    best_idx = '0;
    for (int k = 1; k < tqle_pkg::NUM_ACTIONS; k++) begin
      if (ent[k] > best_val) begin
        best_val = ent[k];
        best_idx = tqle_pkg::ACT_W'(k);
      end
    end
  end

  always_comb begin
    if (rand_percent <= explore_percent || sum == '0) begin
      next_action = rand_action;
      explored    = 1'b1;
    end else begin
      next_action = best_idx;
      explored    = 1'b0;
    end
  end

endmodule

@@ hw/rtl/tabular_q_learning_engine_unit.sv @@
// Top level of the tabular Q-learning engine: sequencer, config registers, Q-table RAM.
// Depends on tqle_pkg, tqle_in_if, tqle_out_if, tqle_ram, tqle_update, tqle_choose.
//
//   channel  | direction | handshake         | payload
//   in_ch    | in        | valid/ready       | do_update, prev/cur coords, action, reward, rand
//   out_ch   | out       | valid/ready       | next_action, explored, new_value
//   cfg_*    | in        | cfg_we, no stall  | cfg_index, cfg_wdata
//
// One item at a time: the Q-table RAM's single read port fetches the current row,
// then the previous row, two multiply stages follow, then write-back and the choice.
// After reset the RAM is swept to zero, one row a cycle, all 2^(X_BITS+Y_BITS) rows with
// in_ch.ready low; config writes are taken throughout.
// The result sits in an output register; a stalled out_ch holds the sequencer in its
// last step, and the next item may be accepted while a result waits.
`include "tabular_q_learning_engine_unit_defines.svh"

module tabular_q_learning_engine_unit #(
  parameter int X_BITS  = 8,
  parameter int Y_BITS  = 8,
  parameter int Q_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tqle_in_if.sink                           in_ch,
  tqle_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [tqle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tqle_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int ROW_W = X_BITS + Y_BITS;
  localparam int DEPTH = 1 << ROW_W;
  localparam int RW    = tqle_pkg::NUM_ACTIONS * Q_WIDTH;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b00000001,
    ST_IDLE    = 8'b00000010,
    ST_RD_CUR  = 8'b00000100,
    ST_RD_PREV = 8'b00001000,
    ST_MUL1    = 8'b00010000,
    ST_MUL2    = 8'b00100000,
    ST_WB      = 8'b01000000,
    ST_DEC     = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [ROW_W-1:0] clr_cnt_r;

  logic [tqle_pkg::RATE_W-1:0] lr_r, disc_r;
  logic [tqle_pkg::PCT_W-1:0]  expl_r;
  logic [tqle_pkg::RATE_W-1:0] alpha, gamma;

  // Item fields held for the whole pass
  logic                               do_update_r;
  logic [ROW_W-1:0]                   prev_row_r, cur_row_r;
  logic [tqle_pkg::ACT_W-1:0]         prev_action_r;
  logic signed [tqle_pkg::REWARD_W-1:0] reward_r;
  logic [tqle_pkg::PCT_W-1:0]         rand_pct_r;
  logic [tqle_pkg::ACT_W-1:0]         rand_act_r;

  logic [RW-1:0]             cur_data_r, prev_data_r, choice_row_r;
  logic signed [Q_WIDTH-1:0] m_r, q_r, value_r;

  logic                               out_valid_r;
  logic [tqle_pkg::ACT_W-1:0]         out_action_r;
  logic                               out_explored_r;
  logic signed [Q_WIDTH-1:0]          out_value_r;

  logic                       in_fire, out_load;
  logic [X_BITS+7:0]          px_ext, cx_ext;
  logic [Y_BITS+7:0]          py_ext, cy_ext;
  logic [ROW_W-1:0]           prev_row_in, cur_row_in;
  logic                       mem_we;
  logic [ROW_W-1:0]           mem_waddr, mem_raddr;
  logic [RW-1:0]              mem_wdata, mem_rdata;
  logic signed [Q_WIDTH-1:0]  rd_ent [tqle_pkg::NUM_ACTIONS];
  logic signed [Q_WIDTH-1:0]  rd_max, rd_q;
  logic signed [Q_WIDTH-1:0]  upd_val;
  logic [RW-1:0]              new_row;
  tqle_pkg::upd_ctl_t         upd_ctl;
  logic [tqle_pkg::ACT_W-1:0] ch_action;
  logic                       ch_explored;
  logic signed [31:0]         value_ext;

  // Coordinates keep their low bits; zero-extend first so any table size works
  always_comb begin
    px_ext      = {{X_BITS{1'b0}}, in_ch.prev_x};
    py_ext      = {{Y_BITS{1'b0}}, in_ch.prev_y};
    cx_ext      = {{X_BITS{1'b0}}, in_ch.cur_x};
    cy_ext      = {{Y_BITS{1'b0}}, in_ch.cur_y};
    prev_row_in = {px_ext[X_BITS-1:0], py_ext[Y_BITS-1:0]};
    cur_row_in  = {cx_ext[X_BITS-1:0], cy_ext[Y_BITS-1:0]};
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DEC) && (!out_valid_r || out_ch.ready);

  assign alpha = (lr_r   > tqle_pkg::RATE_ONE) ? tqle_pkg::RATE_ONE : lr_r;
  assign gamma = (disc_r > tqle_pkg::RATE_ONE) ? tqle_pkg::RATE_ONE : disc_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_fire) state_nxt = ST_RD_CUR;
      ST_RD_CUR:  state_nxt = ST_RD_PREV;
      ST_RD_PREV: state_nxt = ST_MUL1;
      ST_MUL1:    state_nxt = ST_MUL2;
      ST_MUL2:    state_nxt = ST_WB;
      ST_WB:      state_nxt = ST_DEC;
      ST_DEC:     if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Current row is fetched at accept, previous row in the cycle after
  assign mem_raddr = (state_r == ST_RD_CUR) ? prev_row_r : cur_row_in;
  assign mem_we    = (state_r == ST_CLEAR) || ((state_r == ST_WB) && do_update_r);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : prev_row_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : new_row;

  tqle_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_qtab (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    for (int k = 0; k < tqle_pkg::NUM_ACTIONS; k++) begin
      rd_ent[k] = mem_rdata[k*Q_WIDTH +: Q_WIDTH];
    end
    rd_max = rd_ent[0];
    for (int k = 1; k < tqle_pkg::NUM_ACTIONS; k++) begin
      if (rd_ent[k] > rd_max) rd_max = rd_ent[k];
    end
    rd_q = rd_ent[prev_action_r];
  end

  assign upd_ctl.mul1_en = (state_r == ST_MUL1);
  assign upd_ctl.mul2_en = (state_r == ST_MUL2);

  tqle_update #(
    .Q_WIDTH (Q_WIDTH)
  ) u_update (
    .clk     (clk),
    .ctl     (upd_ctl),
    .q_old   (q_r),
    .q_max   (m_r),
    .reward  (reward_r),
    .alpha   (alpha),
    .gamma   (gamma),
    .new_val (upd_val)
  );

  always_comb begin
    for (int k = 0; k < tqle_pkg::NUM_ACTIONS; k++) begin
      new_row[k*Q_WIDTH +: Q_WIDTH] = (tqle_pkg::ACT_W'(k) == prev_action_r) ?
                                      upd_val : prev_data_r[k*Q_WIDTH +: Q_WIDTH];
    end
  end

  tqle_choose #(
    .Q_WIDTH (Q_WIDTH)
  ) u_choose (
    .row             (choice_row_r),
    .rand_percent    (rand_pct_r),
    .explore_percent (expl_r),
    .rand_action     (rand_act_r),
    .next_action     (ch_action),
    .explored        (ch_explored)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      lr_r        <= tqle_pkg::LR_RESET;
      disc_r      <= tqle_pkg::DISC_RESET;
      expl_r      <= tqle_pkg::EXPLORE_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          tqle_pkg::CFG_LEARNING_RATE:   lr_r   <= cfg_wdata;
          tqle_pkg::CFG_DISCOUNT:        disc_r <= cfg_wdata;
          tqle_pkg::CFG_EXPLORE_PERCENT: expl_r <= cfg_wdata[tqle_pkg::PCT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      do_update_r   <= in_ch.do_update;
      prev_row_r    <= prev_row_in;
      cur_row_r     <= cur_row_in;
      prev_action_r <= in_ch.prev_action;
      reward_r      <= in_ch.step_reward;
      rand_pct_r    <= in_ch.rand_percent;
      rand_act_r    <= in_ch.rand_action;
    end
    if (state_r == ST_RD_CUR) begin
      cur_data_r <= mem_rdata;
      m_r        <= rd_max;
    end
    if (state_r == ST_RD_PREV) begin
      prev_data_r <= mem_rdata;
      q_r         <= rd_q;
    end
    if (state_r == ST_WB) begin
      // Choice sees the table after the write when both states match
      choice_row_r <= (do_update_r && (prev_row_r == cur_row_r)) ? new_row : cur_data_r;
      value_r      <= do_update_r ? upd_val : '0;
    end
    if (out_load) begin
      out_action_r   <= ch_action;
      out_explored_r <= ch_explored;
      out_value_r    <= value_r;
    end
  end

  assign value_ext          = 32'(out_value_r);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_action = out_action_r;
  assign out_ch.explored    = out_explored_r;
  assign out_ch.new_value   = value_ext[tqle_pkg::OUT_VAL_W-1:0];

  `TQLE_ASSERT_NEXT(a_accept_reads_cur, in_fire, state_r == ST_RD_CUR, "accept did not start read")
  `TQLE_ASSERT_IMPLY(a_clear_zero, state_r == ST_CLEAR, mem_we && mem_wdata == '0, "clear sweep bad")
  `TQLE_ASSERT_IMPLY(a_idle_no_write, state_r == ST_IDLE, !mem_we, "table written while idle")
  `TQLE_ASSERT_IMPLY(a_result_src, $rose(out_valid_r), $past(state_r == ST_DEC), "stray result")

endmodule
